/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(name, clk, rst_n, cond) \
  `ASSERT_PROP(name, clk, rst_n, !(cond))
`else
`define ASSERT_PROP(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

/* rtl/blr_pkg.sv */
// ----------------------------------------------------------------------------
// Line rasterizer package
// Shared types and fixed constants of the line rasterizer.
// ----------------------------------------------------------------------------
package blr_pkg;

  localparam int unsigned DIM_BITS   = 13;
  localparam int unsigned PITCH_BITS = 16;
  localparam int unsigned ADDR_BITS  = 32;
  localparam int unsigned COLOR_BITS = 32;
  localparam int unsigned BPP_SHIFT  = 2;   // 4 bytes per pixel

  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned LVL_W     = 3;    // holds 0..OUT_DEPTH

  localparam logic [DIM_BITS-1:0]   WIDTH_RST  = 13'd640;
  localparam logic [DIM_BITS-1:0]   HEIGHT_RST = 13'd480;
  localparam logic [PITCH_BITS-1:0] PITCH_RST  = 16'd2560;
  localparam logic [ADDR_BITS-1:0]  BASE_RST   = 32'd0;

  typedef enum logic {
    OP_STEP  = 1'b0,
    OP_START = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_PITCH  = 2'd2,
    CFG_BASE   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [LVL_W-1:0] level;
  } q_stat_t;

endpackage

/* rtl/blr_queue.sv */
// ----------------------------------------------------------------------------
// Word queue
// Small register FIFO with a combinational head; DEPTH is a power of two.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module blr_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic                 pop_i,
  output logic [WIDTH-1:0]     rdata_o,
  output blr_pkg::q_stat_t     stat_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [blr_pkg::LVL_W-1:0] DEPTH_LVL = DEPTH[blr_pkg::LVL_W-1:0];

  logic [WIDTH-1:0]          slots_q [DEPTH];
  logic [PTR_W-1:0]          wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]          rd_ptr_q, rd_ptr_d;
  logic [blr_pkg::LVL_W-1:0] level_q, level_d;
  logic                      do_push, do_pop;

  assign do_push = push_i && (level_q != DEPTH_LVL);
  assign do_pop  = pop_i && (level_q != '0);

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    level_d  = level_q;
    case ({do_push, do_pop})
      2'b10:   level_d = level_q + 1'b1;
      2'b01:   level_d = level_q - 1'b1;
      default: level_d = level_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o      = slots_q[rd_ptr_q];
  assign stat_o.full  = (level_q == DEPTH_LVL);
  assign stat_o.empty = (level_q == '0);
  assign stat_o.level = level_q;

  `ASSERT_NEVER(a_push_when_full, clk_i, rst_ni, push_i && stat_o.full)
  `ASSERT_NEVER(a_pop_when_empty, clk_i, rst_ni, pop_i && stat_o.empty)
  `ASSERT_PROP(a_level_in_range, clk_i, rst_ni, level_q <= DEPTH_LVL)

endmodule

/* rtl/blr_front.sv */
// ----------------------------------------------------------------------------
// Line rasterizer front end
// Classifies input words and works out the Bresenham setup for a start.
// ----------------------------------------------------------------------------
module blr_front #(
  parameter int unsigned COORD_BITS = 13
) (
  input  logic                                op_i,
  input  logic signed [COORD_BITS-1:0]        start_x_i,
  input  logic signed [COORD_BITS-1:0]        start_y_i,
  input  logic signed [COORD_BITS-1:0]        end_x_i,
  input  logic signed [COORD_BITS-1:0]        end_y_i,
  input  logic [blr_pkg::COLOR_BITS-1:0]      line_color_i,
  output logic [6*COORD_BITS+blr_pkg::COLOR_BITS+16:0] cmd_data_o
);

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned DEC_W = COORD_BITS + 4;

  logic signed [C:0]  dx, dy;
  logic [C:0]         dx_neg, dy_neg;
  logic               x_neg, y_neg, x_major, active;
  logic [C-1:0]       w, h;
  logic [DEC_W-1:0]   w_d, h_d, w2, h2;
  logic [DEC_W-1:0]   decision, inc_hold, inc_step;
  logic [C-1:0]       major_end;

  assign dx     = {end_x_i[C-1], end_x_i} - {start_x_i[C-1], start_x_i};
  assign dy     = {end_y_i[C-1], end_y_i} - {start_y_i[C-1], start_y_i};
  assign dx_neg = -dx;
  assign dy_neg = -dy;
  assign x_neg  = dx[C];
  assign y_neg  = dy[C];
  assign w      = x_neg ? dx_neg[C-1:0] : dx[C-1:0];
  assign h      = y_neg ? dy_neg[C-1:0] : dy[C-1:0];
  assign x_major = (w >= h);

  assign w_d = {{(DEC_W-C){1'b0}}, w};
  assign h_d = {{(DEC_W-C){1'b0}}, h};
  assign w2  = {w_d[DEC_W-2:0], 1'b0};
  assign h2  = {h_d[DEC_W-2:0], 1'b0};

  assign decision  = x_major ? h2 - w_d : w2 - h_d;
  assign inc_hold  = x_major ? h2 : w2;
  assign inc_step  = x_major ? h2 - w2 : w2 - h2;
  assign major_end = x_major ? end_x_i : end_y_i;
  // A line with equal endpoints on the major axis ends on its first pixel.
  assign active    = x_major ? (start_x_i != end_x_i) : (start_y_i != end_y_i);

  assign cmd_data_o = {op_i, start_x_i, start_y_i, major_end, x_neg, y_neg, x_major,
                       decision, inc_hold, inc_step, line_color_i, active};

endmodule

/* rtl/blr_back.sv */
// ----------------------------------------------------------------------------
// Line rasterizer back end
// Steps the decision variable, then forms clip flag and byte address.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module blr_back #(
  parameter int unsigned COORD_BITS = 13
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [6*COORD_BITS+blr_pkg::COLOR_BITS+16:0] cmd_data_i,
  input  blr_pkg::q_stat_t                     cmd_stat_i,
  output logic                                 cmd_pop_o,
  input  blr_pkg::q_stat_t                     out_stat_i,
  output logic                                 out_push_o,
  output logic [2*COORD_BITS+blr_pkg::COLOR_BITS+blr_pkg::ADDR_BITS+1:0] out_data_o,
  input  logic [blr_pkg::DIM_BITS-1:0]         frame_width_i,
  input  logic [blr_pkg::DIM_BITS-1:0]         frame_height_i,
  input  logic [blr_pkg::PITCH_BITS-1:0]       row_pitch_i,
  input  logic [blr_pkg::ADDR_BITS-1:0]        frame_base_i
);

  localparam int unsigned C      = COORD_BITS;
  localparam int unsigned DEC_W  = COORD_BITS + 4;
  localparam int unsigned AW     = blr_pkg::ADDR_BITS;
  localparam int unsigned PROD_W = COORD_BITS + blr_pkg::PITCH_BITS + 1;
  localparam int unsigned CMP_W  =
    ((COORD_BITS > blr_pkg::DIM_BITS) ? COORD_BITS : blr_pkg::DIM_BITS) + 1;
  localparam int unsigned SLOT_W = blr_pkg::LVL_W + 1;
  localparam logic [SLOT_W-1:0] OUT_DEPTH_W = blr_pkg::OUT_DEPTH[SLOT_W-1:0];

  // command fields
  logic                            cmd_op;
  logic [C-1:0]                    cmd_x0, cmd_y0, cmd_end;
  logic                            cmd_xneg, cmd_yneg, cmd_xmaj, cmd_active;
  logic [DEC_W-1:0]                cmd_dec, cmd_hold, cmd_step;
  logic [blr_pkg::COLOR_BITS-1:0]  cmd_color;

  // stepper state
  logic                            line_active_q, line_active_d;
  logic [C-1:0]                    cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [C-1:0]                    major_end_q, major_end_d;
  logic                            x_dir_neg_q, x_dir_neg_d, y_dir_neg_q, y_dir_neg_d;
  logic                            x_major_q, x_major_d;
  logic [DEC_W-1:0]                decision_q, decision_d;
  logic [DEC_W-1:0]                inc_hold_q, inc_hold_d, inc_step_q, inc_step_d;
  logic [blr_pkg::COLOR_BITS-1:0]  held_color_q, held_color_d;
  logic                            s1_valid_q, s1_valid_d;

  logic                            issue, minor, nx_active;
  logic [SLOT_W-1:0]               slots_used;
  logic [C-1:0]                    step_x, step_y, nx_x, nx_y;
  logic [DEC_W-1:0]                nx_dec;

  // address stage
  logic                            s2_valid_q;
  logic [C-1:0]                    s2_x_q, s2_y_q;
  logic [blr_pkg::COLOR_BITS-1:0]  s2_color_q;
  logic signed [PROD_W-1:0]        s2_prod_q;
  logic                            s2_we_q, s2_last_q;
  logic signed [PROD_W-1:0]        prod;
  logic [CMP_W-1:0]                x_cmp, y_cmp, w_cmp, h_cmp;
  logic                            in_frame;
  logic [AW+PROD_W-1:0]            prod_ext;
  logic [AW+C+blr_pkg::BPP_SHIFT-1:0] x_off;
  logic [AW-1:0]                   byte_addr;

  assign {cmd_op, cmd_x0, cmd_y0, cmd_end, cmd_xneg, cmd_yneg, cmd_xmaj,
          cmd_dec, cmd_hold, cmd_step, cmd_color, cmd_active} = cmd_data_i;

  // Reserve an output slot for every word still in flight.
  assign slots_used = {1'b0, out_stat_i.level} + {{(SLOT_W-1){1'b0}}, s1_valid_q}
                      + {{(SLOT_W-1){1'b0}}, s2_valid_q};
  assign issue      = !cmd_stat_i.empty && (slots_used < OUT_DEPTH_W);
  assign cmd_pop_o  = issue;

  assign step_x    = x_dir_neg_q ? {C{1'b1}} : {{(C-1){1'b0}}, 1'b1};
  assign step_y    = y_dir_neg_q ? {C{1'b1}} : {{(C-1){1'b0}}, 1'b1};
  assign minor     = !decision_q[DEC_W-1];
  assign nx_x      = (x_major_q || minor) ? cur_x_q + step_x : cur_x_q;
  assign nx_y      = (!x_major_q || minor) ? cur_y_q + step_y : cur_y_q;
  assign nx_dec    = decision_q + (minor ? inc_step_q : inc_hold_q);
  assign nx_active = (x_major_q ? nx_x : nx_y) != major_end_q;

  always_comb begin
    line_active_d = line_active_q;
    cur_x_d       = cur_x_q;
    cur_y_d       = cur_y_q;
    major_end_d   = major_end_q;
    x_dir_neg_d   = x_dir_neg_q;
    y_dir_neg_d   = y_dir_neg_q;
    x_major_d     = x_major_q;
    decision_d    = decision_q;
    inc_hold_d    = inc_hold_q;
    inc_step_d    = inc_step_q;
    held_color_d  = held_color_q;
    s1_valid_d    = 1'b0;
    if (issue) begin
      if (cmd_op == blr_pkg::OP_START) begin
        // drop any running line and load the new one
        line_active_d = cmd_active;
        cur_x_d       = cmd_x0;
        cur_y_d       = cmd_y0;
        major_end_d   = cmd_end;
        x_dir_neg_d   = cmd_xneg;
        y_dir_neg_d   = cmd_yneg;
        x_major_d     = cmd_xmaj;
        decision_d    = cmd_dec;
        inc_hold_d    = cmd_hold;
        inc_step_d    = cmd_step;
        held_color_d  = cmd_color;
        s1_valid_d    = 1'b1;
      end else if (line_active_q) begin
        line_active_d = nx_active;
        cur_x_d       = nx_x;
        cur_y_d       = nx_y;
        decision_d    = nx_dec;
        s1_valid_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_active_q <= 1'b0;
      s1_valid_q    <= 1'b0;
      s2_valid_q    <= 1'b0;
    end else begin
      line_active_q <= line_active_d;
      s1_valid_q    <= s1_valid_d;
      s2_valid_q    <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q      <= cur_x_d;
    cur_y_q      <= cur_y_d;
    major_end_q  <= major_end_d;
    x_dir_neg_q  <= x_dir_neg_d;
    y_dir_neg_q  <= y_dir_neg_d;
    x_major_q    <= x_major_d;
    decision_q   <= decision_d;
    inc_hold_q   <= inc_hold_d;
    inc_step_q   <= inc_step_d;
    held_color_q <= held_color_d;
  end

  // Pixel on the stepper registers: clip and row offset.
  assign prod   = $signed(cur_y_q) * $signed({1'b0, row_pitch_i});
  assign x_cmp  = {{(CMP_W-C){1'b0}}, cur_x_q};
  assign y_cmp  = {{(CMP_W-C){1'b0}}, cur_y_q};
  assign w_cmp  = {{(CMP_W-blr_pkg::DIM_BITS){1'b0}}, frame_width_i};
  assign h_cmp  = {{(CMP_W-blr_pkg::DIM_BITS){1'b0}}, frame_height_i};
  assign in_frame = !cur_x_q[C-1] && !cur_y_q[C-1] && (x_cmp < w_cmp) && (y_cmp < h_cmp);

  always_ff @(posedge clk_i) begin
    s2_x_q     <= cur_x_q;
    s2_y_q     <= cur_y_q;
    s2_color_q <= held_color_q;
    s2_prod_q  <= prod;
    s2_we_q    <= in_frame;
    s2_last_q  <= !line_active_q;
  end

  assign prod_ext  = {{AW{s2_prod_q[PROD_W-1]}}, s2_prod_q};
  assign x_off     = {{AW{s2_x_q[C-1]}}, s2_x_q, {blr_pkg::BPP_SHIFT{1'b0}}};
  assign byte_addr = frame_base_i + prod_ext[AW-1:0] + x_off[AW-1:0];

  assign out_push_o = s2_valid_q;
  assign out_data_o = {s2_x_q, s2_y_q, s2_color_q, byte_addr, s2_we_q, s2_last_q};

  `ASSERT_PROP(a_idle_step_silent, clk_i, rst_ni,
    (issue && (cmd_op == blr_pkg::OP_STEP) && !line_active_q) |=> !s1_valid_q)
  `ASSERT_PROP(a_out_credit, clk_i, rst_ni, slots_used <= OUT_DEPTH_W)
  `ASSERT_NEVER(a_no_push_into_full, clk_i, rst_ni, out_push_o && out_stat_i.full)

endmodule

/* rtl/bresenham_line_rasterizer.sv */
// Path: a word taken into the command queue passes the stepper, the multiply register
// and the address add into the result queue, which absorbs pop stalls until it fills.
// Throughput: one word per cycle, set by the stepper's single add and compare on the
// decision variable, while the result queue holds a slot for every word in flight.
// Reset (async, low): no line active, both queues empty, frame 640x480,
// pitch 2560, base 0.
// ----------------------------------------------------------------------------
// Bresenham line rasterizer
// Emits one framebuffer pixel word per start word and per step word of an active line.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer #(
  parameter int unsigned COORD_BITS = 13
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input words
  input  logic                              push,
  output logic                              full,
  input  logic                              op_i,
  input  logic signed [COORD_BITS-1:0]      start_x_i,
  input  logic signed [COORD_BITS-1:0]      start_y_i,
  input  logic signed [COORD_BITS-1:0]      end_x_i,
  input  logic signed [COORD_BITS-1:0]      end_y_i,
  input  logic [blr_pkg::COLOR_BITS-1:0]    line_color_i,
  // result words
  output logic                              empty,
  input  logic                              pop,
  output logic signed [COORD_BITS-1:0]      pixel_x_o,
  output logic signed [COORD_BITS-1:0]      pixel_y_o,
  output logic [blr_pkg::COLOR_BITS-1:0]    pixel_color_o,
  output logic [blr_pkg::ADDR_BITS-1:0]     byte_address_o,
  output logic                              write_enable_o,
  output logic                              last_pixel_o,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [1:0]                        cfg_index_i,
  input  logic [31:0]                       cfg_wdata_i
);

  localparam int unsigned CMD_W = 6*COORD_BITS + blr_pkg::COLOR_BITS + 17;
  localparam int unsigned OUT_W = 2*COORD_BITS + blr_pkg::COLOR_BITS
                                  + blr_pkg::ADDR_BITS + 2;

  logic [blr_pkg::DIM_BITS-1:0]   frame_width_q, frame_height_q;
  logic [blr_pkg::PITCH_BITS-1:0] row_pitch_q;
  logic [blr_pkg::ADDR_BITS-1:0]  frame_base_q;
  logic                           cfg_we;

  logic [CMD_W-1:0]               cmd_wdata, cmd_rdata;
  blr_pkg::q_stat_t               cmd_stat, out_stat;
  logic                           cmd_push, cmd_pop;
  logic [OUT_W-1:0]               out_wdata, out_rdata;
  logic                           out_push, out_pop;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= blr_pkg::WIDTH_RST;
      frame_height_q <= blr_pkg::HEIGHT_RST;
      row_pitch_q    <= blr_pkg::PITCH_RST;
      frame_base_q   <= blr_pkg::BASE_RST;
    end else if (cfg_we) begin
      case (blr_pkg::cfg_idx_e'(cfg_index_i))
        blr_pkg::CFG_WIDTH:  frame_width_q  <= cfg_wdata_i[blr_pkg::DIM_BITS-1:0];
        blr_pkg::CFG_HEIGHT: frame_height_q <= cfg_wdata_i[blr_pkg::DIM_BITS-1:0];
        blr_pkg::CFG_PITCH:  row_pitch_q    <= cfg_wdata_i[blr_pkg::PITCH_BITS-1:0];
        blr_pkg::CFG_BASE:   frame_base_q   <= cfg_wdata_i[blr_pkg::ADDR_BITS-1:0];
        default: ;
      endcase
    end
  end

  blr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .op_i        (op_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .line_color_i(line_color_i),
    .cmd_data_o  (cmd_wdata)
  );

  assign full     = cmd_stat.full;
  assign cmd_push = push && !cmd_stat.full;

  blr_queue #(
    .WIDTH(CMD_W),
    .DEPTH(blr_pkg::CMD_DEPTH)
  ) u_cmd_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .wdata_i(cmd_wdata),
    .pop_i  (cmd_pop),
    .rdata_o(cmd_rdata),
    .stat_o (cmd_stat)
  );

  blr_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_data_i    (cmd_rdata),
    .cmd_stat_i    (cmd_stat),
    .cmd_pop_o     (cmd_pop),
    .out_stat_i    (out_stat),
    .out_push_o    (out_push),
    .out_data_o    (out_wdata),
    .frame_width_i (frame_width_q),
    .frame_height_i(frame_height_q),
    .row_pitch_i   (row_pitch_q),
    .frame_base_i  (frame_base_q)
  );

  assign out_pop = pop && !out_stat.empty;

  blr_queue #(
    .WIDTH(OUT_W),
    .DEPTH(blr_pkg::OUT_DEPTH)
  ) u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .wdata_i(out_wdata),
    .pop_i  (out_pop),
    .rdata_o(out_rdata),
    .stat_o (out_stat)
  );

  assign empty = out_stat.empty;
  assign {pixel_x_o, pixel_y_o, pixel_color_o, byte_address_o,
          write_enable_o, last_pixel_o} = out_rdata;

endmodule
